>>> rtl/core/fpp_pkg.sv
// Shared types and constants for the fermion permutation parity relabeler.
`timescale 1ns / 1ps
package fpp_pkg;

	localparam int OCC_W     = 32;  // site occupation / canonical occupation width
	localparam int MAP_W     = 64;  // packed orbital map width
	localparam int MASK_W    = 16;  // sign mask width
	localparam int ORB_W     = 4;   // one orbital index
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 64;

	localparam logic [MAP_W-1:0] MAP_RESET = 64'hFEDC_BA98_7654_3210;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORBITAL_MAP = 1'b0,
		CFG_SIGN_MASK   = 1'b1
	} cfg_reg_t;

	// What one lane reports for its site.
	typedef struct packed {
		logic [OCC_W-1:0] canon;   // occupation bits this site drops into orbital order
		logic             parity;  // sign and inversion parity owned by this site
	} fpp_lane_res_t;

endpackage

>>> rtl/core/fpp_lane.sv
// One site lane: places the site's occupations and counts its parity share.
`timescale 1ns / 1ps
module fpp_lane
	import fpp_pkg::*;
#(
	parameter int SITES = 16,
	parameter int LANE  = 0
) (
	input  logic [SITES-1:0][ORB_W-1:0] site_orb,
	input  logic [SITES-1:0]            alpha,
	input  logic [SITES-1:0]            beta,
	input  logic                        negative,
	output fpp_lane_res_t               res
);

	// Parity owned by this lane: own sign flips, plus every pair where this
	// site comes first. Alpha-alpha and beta-beta pairs invert on p_k > p_j;
	// a beta here always sits above any alpha later, so each such pair inverts.
	always_comb begin
		res = '0;
		for (int o = 0; o < SITES; o++) begin
			res.canon[2*o]   = alpha[LANE] & (site_orb[LANE] == ORB_W'(o));
			res.canon[2*o+1] = beta[LANE] & (site_orb[LANE] == ORB_W'(o));
		end
		res.parity = (alpha[LANE] ^ beta[LANE]) & negative;
		for (int j = LANE + 1; j < SITES; j++) begin
			res.parity = res.parity
				^ ((site_orb[LANE] > site_orb[j])
					& ((alpha[LANE] & alpha[j]) ^ (beta[LANE] & beta[j])))
				^ (beta[LANE] & alpha[j]);
		end
	end

endmodule

>>> rtl/core/fpp_merge.sv
// Merge stage: ORs the lanes' occupations and XORs their parity shares.
`timescale 1ns / 1ps
module fpp_merge
	import fpp_pkg::*;
#(
	parameter int SITES = 16
) (
	input  fpp_lane_res_t [SITES-1:0] lanes,
	output fpp_lane_res_t             merged
);

	always_comb begin
		merged = '0;
		for (int k = 0; k < SITES; k++) begin
			merged.canon  = merged.canon | lanes[k].canon;
			merged.parity = merged.parity ^ lanes[k].parity;
		end
	end

endmodule

>>> rtl/core/determinant_relabel_with_fermion_sign.sv
// Top level of the fermion permutation parity relabeler.
`timescale 1ns / 1ps
// Relabels one Slater determinant (2 occupation bits per lattice site, bit0
// alpha, bit1 beta) into canonical orbital order using the orbital_map
// register, and returns the relabeled occupations with a phase bit. The phase
// flips once per occupied spin orbital on a site marked in sign_mask and once
// more when the spin-orbital sequence (sites in order, alpha before beta,
// alpha value p, beta value SITES+p) has odd inversion parity. Map entries at
// or above SITES drop that site; colliding map entries OR their occupations.
// Throughput is one determinant per clock while out_ready stays high. A
// determinant taken in passes through three stages, which are the input
// register, the lane result register and the output register. One lane per
// site works out its own placement and its share of the parity against
// all later sites; the merge stage ORs and XORs the lanes. Register writes
// (cfg_index 0: orbital_map, 1: sign_mask, low 16 data bits) are taken every
// cycle and must only be issued while no determinant is in flight.
module determinant_relabel_with_fermion_sign
	import fpp_pkg::*;
#(
	parameter int SITES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// determinant in
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [OCC_W-1:0]     site_occ,
	// relabeled determinant out
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OCC_W-1:0]     canon_occ,
	output logic                 phase_negative
);

	localparam logic [ORB_W:0] SITES_LIM = (ORB_W + 1)'(SITES);

	// ---------------- configuration registers ----------------
	logic [MAP_W-1:0]  orbital_map_q;
	logic [MASK_W-1:0] sign_mask_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orbital_map_q <= MAP_RESET;
			sign_mask_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ORBITAL_MAP: orbital_map_q <= cfg_data;
				CFG_SIGN_MASK:   sign_mask_q   <= cfg_data[MASK_W-1:0];
				default:         ;
			endcase
		end
	end

	// ---------------- pipeline flow control ----------------
	// Each stage loads whenever it is empty or the stage after it moves on.
	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// ---------------- stage 1: input register ----------------
	logic [OCC_W-1:0] occ_s1;

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			occ_s1 <= site_occ;
		end
	end

	// Per-site decode: mapped orbital, and occupations cleared for sites whose
	// map entry falls outside the orbital range.
	logic [SITES-1:0][ORB_W-1:0] site_orb;
	logic [SITES-1:0]            alpha_eff;
	logic [SITES-1:0]            beta_eff;

	always_comb begin
		for (int k = 0; k < SITES; k++) begin
			site_orb[k]  = orbital_map_q[ORB_W*k +: ORB_W];
			alpha_eff[k] = occ_s1[2*k] & ({1'b0, site_orb[k]} < SITES_LIM);
			beta_eff[k]  = occ_s1[2*k+1] & ({1'b0, site_orb[k]} < SITES_LIM);
		end
	end

	// ---------------- lanes, one per site ----------------
	fpp_lane_res_t [SITES-1:0] lane_res;
	fpp_lane_res_t [SITES-1:0] lane_res_s2;

	for (genvar k = 0; k < SITES; k++) begin : g_lane
		fpp_lane #(
			.SITES (SITES),
			.LANE  (k)
		) u_lane (
			.site_orb (site_orb),
			.alpha    (alpha_eff),
			.beta     (beta_eff),
			.negative (sign_mask_q[k]),
			.res      (lane_res[k])
		);
	end

	// ---------------- stage 2: lane results ----------------
	always_ff @(posedge clk) begin
		if (v_s1 && rdy2) begin
			lane_res_s2 <= lane_res;
		end
	end

	fpp_lane_res_t merged;

	fpp_merge #(
		.SITES (SITES)
	) u_merge (
		.lanes  (lane_res_s2),
		.merged (merged)
	);

	// ---------------- stage 3: output register ----------------
	logic [OCC_W-1:0] canon_s3;
	logic             phase_s3;

	always_ff @(posedge clk) begin
		if (v_s2 && rdy3) begin
			canon_s3 <= merged.canon;
			phase_s3 <= merged.parity;
		end
	end

	assign canon_occ      = canon_s3;
	assign phase_negative = phase_s3;

	// ---------------- assertions ----------------
	// No orbital slot at or above SITES ever gets an occupation bit.
	a_canon_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((canon_occ >> (2 * SITES)) == '0))
		else $error("canon_occ has bits beyond the orbital range");

	// A new result only appears when the lane stage held one.
	a_out_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s2))
		else $error("result appeared without a lane result behind it");

	// A full pipeline facing a stall must refuse new input.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && !out_ready) |-> !in_ready)
		else $error("input accepted while pipeline is full and stalled");

	// Input register only empties toward stage 2 when stage 2 can take it.
	a_s1_move: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !rdy2) |=> v_s1)
		else $error("stage 1 item lost during stall");

endmodule
